// ----- src/cbu_pkg.sv -----
// Package for the color blend unit: blend factor and equation codes,
// register indexes and the control structs shared by the lanes and the top.
// No dependencies.
package cbu_pkg;

   // Blend factor codes; code 15 is unused and acts as zero
   typedef enum logic [3:0] {
      FACTOR_ZERO          = 4'd0,
      FACTOR_ONE           = 4'd1,
      FACTOR_SRC_COLOR     = 4'd2,
      FACTOR_INV_SRC_COLOR = 4'd3,
      FACTOR_DST_COLOR     = 4'd4,
      FACTOR_INV_DST_COLOR = 4'd5,
      FACTOR_SRC_ALPHA     = 4'd6,
      FACTOR_INV_SRC_ALPHA = 4'd7,
      FACTOR_DST_ALPHA     = 4'd8,
      FACTOR_INV_DST_ALPHA = 4'd9,
      FACTOR_CONST_COLOR   = 4'd10,
      FACTOR_INV_CONST_COLOR = 4'd11,
      FACTOR_CONST_ALPHA   = 4'd12,
      FACTOR_INV_CONST_ALPHA = 4'd13,
      FACTOR_ALPHA_SAT     = 4'd14
   } factor_type;

   // Blend equations; unused codes give zero
   typedef enum logic [2:0] {
      EQ_ADD     = 3'd0,
      EQ_SUB     = 3'd1,
      EQ_REV_SUB = 3'd2,
      EQ_MIN     = 3'd3,
      EQ_MAX     = 3'd4
   } equation_type;

   // Register indexes on the csr port
   typedef enum logic [2:0] {
      CSR_SRC_FACTOR  = 3'd0,
      CSR_DST_FACTOR  = 3'd1,
      CSR_EQUATION    = 3'd2,
      CSR_CONST_RED   = 3'd3,
      CSR_CONST_GREEN = 3'd4,
      CSR_CONST_BLUE  = 3'd5,
      CSR_CONST_ALPHA = 3'd6
   } csr_index_type;

   localparam int CsrIndexBits = 3;

   // Blend mode seen by every lane
   typedef struct packed {
      factor_type   src_factor;
      factor_type   dst_factor;
      equation_type equation;
   } blend_cfg_type;

   // Stage load enables from the pipeline control
   typedef struct packed {
      logic load_prod;
      logic load_quot;
   } pipe_ctrl_type;

endpackage

// ----- src/color_blend_unit.sv -----
// Color blend unit: an accepted req word passes the product, quotient and output
// registers to rsp_valid, one pixel per cycle; four channel lanes run side by side
// and the output register gathers them; stages stall only when the output is held.
// Reset clears the pipeline valid bits and returns the blend registers to
// src_factor one, dst_factor zero, equation add, constant color zero.
// Depends on cbu_pkg and cbu_lane.
module color_blend_unit #(
   parameter int CHANNEL_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [CHANNEL_BITS-1:0]              req_src_red,
   input  logic [CHANNEL_BITS-1:0]              req_src_green,
   input  logic [CHANNEL_BITS-1:0]              req_src_blue,
   input  logic [CHANNEL_BITS-1:0]              req_src_alpha,
   input  logic [CHANNEL_BITS-1:0]              req_dst_red,
   input  logic [CHANNEL_BITS-1:0]              req_dst_green,
   input  logic [CHANNEL_BITS-1:0]              req_dst_blue,
   input  logic [CHANNEL_BITS-1:0]              req_dst_alpha,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [CHANNEL_BITS-1:0]              rsp_out_red,
   output logic [CHANNEL_BITS-1:0]              rsp_out_green,
   output logic [CHANNEL_BITS-1:0]              rsp_out_blue,
   output logic [CHANNEL_BITS-1:0]              rsp_out_alpha,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cbu_pkg::CsrIndexBits-1:0]     csr_index,
   input  logic [CHANNEL_BITS-1:0]              csr_data
);

   localparam int N = CHANNEL_BITS;
   localparam logic [N-1:0] MaxVal = {N{1'b1}};

   cbu_pkg::blend_cfg_type  cfg_ff, cfg_in;
   logic [N-1:0]            const_ff [4];
   logic [N-1:0]            const_in [4];
   cbu_pkg::pipe_ctrl_type  ctrl;
   logic                    vld_prod_ff, vld_prod_in;
   logic                    vld_quot_ff, vld_quot_in;
   logic                    vld_out_ff, vld_out_in;
   logic                    rdy_prod, rdy_quot, rdy_out;
   logic [N-1:0]            src_ch [4];
   logic [N-1:0]            dst_ch [4];
   logic [N-1:0]            sat_ch [4];
   logic [N-1:0]            lane_res [4];
   logic [N-1:0]            out_ff [4];
   logic [N-1:0]            inv_dst_alpha, sat_rgb;

   // Configuration writes; the port never stalls
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in   = cfg_ff;
      const_in = const_ff;
      if (csr_valid) begin
         unique case (csr_index)
            cbu_pkg::CSR_SRC_FACTOR:
               cfg_in.src_factor = cbu_pkg::factor_type'(csr_data[3:0]);
            cbu_pkg::CSR_DST_FACTOR:
               cfg_in.dst_factor = cbu_pkg::factor_type'(csr_data[3:0]);
            cbu_pkg::CSR_EQUATION:
               cfg_in.equation = cbu_pkg::equation_type'(csr_data[2:0]);
            cbu_pkg::CSR_CONST_RED:   const_in[0] = csr_data;
            cbu_pkg::CSR_CONST_GREEN: const_in[1] = csr_data;
            cbu_pkg::CSR_CONST_BLUE:  const_in[2] = csr_data;
            cbu_pkg::CSR_CONST_ALPHA: const_in[3] = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_factor <= cbu_pkg::FACTOR_ONE;
         cfg_ff.dst_factor <= cbu_pkg::FACTOR_ZERO;
         cfg_ff.equation   <= cbu_pkg::EQ_ADD;
         for (int i = 0; i < 4; i++) begin
            const_ff[i] <= '0;
         end
      end else begin
         cfg_ff   <= cfg_in;
         const_ff <= const_in;
      end
   end

   // Pipeline flow: a stage loads when it is empty or the next one takes its word
   always_comb begin
      rdy_out        = !vld_out_ff || rsp_ready;
      rdy_quot       = !vld_quot_ff || rdy_out;
      rdy_prod       = !vld_prod_ff || rdy_quot;
      req_ready      = rdy_prod;
      ctrl.load_prod = rdy_prod;
      ctrl.load_quot = rdy_quot;
      vld_prod_in    = rdy_prod ? req_valid : vld_prod_ff;
      vld_quot_in    = rdy_quot ? vld_prod_ff : vld_quot_ff;
      vld_out_in     = rdy_out ? vld_quot_ff : vld_out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_prod_ff <= 1'b0;
         vld_quot_ff <= 1'b0;
         vld_out_ff  <= 1'b0;
      end else begin
         vld_prod_ff <= vld_prod_in;
         vld_quot_ff <= vld_quot_in;
         vld_out_ff  <= vld_out_in;
      end
   end

   // Spread the pixel over the lanes; alpha saturate is min(As, 1-Ad), one for alpha
   always_comb begin
      src_ch[0] = req_src_red;
      src_ch[1] = req_src_green;
      src_ch[2] = req_src_blue;
      src_ch[3] = req_src_alpha;
      dst_ch[0] = req_dst_red;
      dst_ch[1] = req_dst_green;
      dst_ch[2] = req_dst_blue;
      dst_ch[3] = req_dst_alpha;
      inv_dst_alpha = MaxVal - req_dst_alpha;
      sat_rgb   = (req_src_alpha < inv_dst_alpha) ? req_src_alpha : inv_dst_alpha;
      sat_ch[0] = sat_rgb;
      sat_ch[1] = sat_rgb;
      sat_ch[2] = sat_rgb;
      sat_ch[3] = MaxVal;
   end

   for (genvar g = 0; g < 4; g++) begin : g_lane
      cbu_lane #(
         .CHANNEL_BITS (CHANNEL_BITS)
      ) u_lane (
         .clock       (clock),
         .ctrl        (ctrl),
         .cfg         (cfg_ff),
         .src_chan    (src_ch[g]),
         .dst_chan    (dst_ch[g]),
         .src_alpha   (req_src_alpha),
         .dst_alpha   (req_dst_alpha),
         .const_chan  (const_ff[g]),
         .const_alpha (const_ff[3]),
         .sat_factor  (sat_ch[g]),
         .result      (lane_res[g])
      );
   end

   // Merge lane results into the output register
   always_ff @(posedge clock) begin
      if (rdy_out) begin
         out_ff <= lane_res;
      end
   end

   assign rsp_valid     = vld_out_ff;
   assign rsp_out_red   = out_ff[0];
   assign rsp_out_green = out_ff[1];
   assign rsp_out_blue  = out_ff[2];
   assign rsp_out_alpha = out_ff[3];

endmodule

// ----- src/cbu_lane.sv -----
// One color channel lane: factor select and multiply, divide by the unorm
// maximum with rounding, then the blend equation (min and max take the raw channels).
// Depends on cbu_pkg.
module cbu_lane #(
   parameter int CHANNEL_BITS = 8
) (
   input  logic                        clock,
   input  cbu_pkg::pipe_ctrl_type      ctrl,
   input  cbu_pkg::blend_cfg_type      cfg,
   input  logic [CHANNEL_BITS-1:0]     src_chan,
   input  logic [CHANNEL_BITS-1:0]     dst_chan,
   input  logic [CHANNEL_BITS-1:0]     src_alpha,
   input  logic [CHANNEL_BITS-1:0]     dst_alpha,
   input  logic [CHANNEL_BITS-1:0]     const_chan,
   input  logic [CHANNEL_BITS-1:0]     const_alpha,
   input  logic [CHANNEL_BITS-1:0]     sat_factor,
   output logic [CHANNEL_BITS-1:0]     result
);

   localparam int N = CHANNEL_BITS;
   localparam int W = 2 * CHANNEL_BITS;
   localparam logic [N-1:0] MaxVal  = {N{1'b1}};
   localparam logic [N-1:0] HalfVal = MaxVal >> 1;

   logic [N-1:0] fac_src, fac_dst;
   logic [W-1:0] prod_src_in, prod_dst_in;
   logic [W-1:0] prod_src_ff, prod_dst_ff;
   logic [N-1:0] src_p_ff, dst_p_ff;
   logic [N-1:0] quot_src_in, quot_dst_in;
   logic [N-1:0] quot_src_ff, quot_dst_ff;
   logic [N-1:0] src_q_ff, dst_q_ff;
   logic [N:0]   sum;

   function automatic logic [N-1:0] pick_factor(
      input cbu_pkg::factor_type code,
      input logic [N-1:0] s, input logic [N-1:0] d,
      input logic [N-1:0] sa, input logic [N-1:0] da,
      input logic [N-1:0] c, input logic [N-1:0] ca,
      input logic [N-1:0] sat);
      logic [N-1:0] f;
      unique case (code)
         cbu_pkg::FACTOR_ZERO:            f = '0;
         cbu_pkg::FACTOR_ONE:             f = MaxVal;
         cbu_pkg::FACTOR_SRC_COLOR:       f = s;
         cbu_pkg::FACTOR_INV_SRC_COLOR:   f = MaxVal - s;
         cbu_pkg::FACTOR_DST_COLOR:       f = d;
         cbu_pkg::FACTOR_INV_DST_COLOR:   f = MaxVal - d;
         cbu_pkg::FACTOR_SRC_ALPHA:       f = sa;
         cbu_pkg::FACTOR_INV_SRC_ALPHA:   f = MaxVal - sa;
         cbu_pkg::FACTOR_DST_ALPHA:       f = da;
         cbu_pkg::FACTOR_INV_DST_ALPHA:   f = MaxVal - da;
         cbu_pkg::FACTOR_CONST_COLOR:     f = c;
         cbu_pkg::FACTOR_INV_CONST_COLOR: f = MaxVal - c;
         cbu_pkg::FACTOR_CONST_ALPHA:     f = ca;
         cbu_pkg::FACTOR_INV_CONST_ALPHA: f = MaxVal - ca;
         cbu_pkg::FACTOR_ALPHA_SAT:       f = sat;
         default:                         f = '0;
      endcase
      return f;
   endfunction

   // (t + (t >> N) + 1) >> N is floor(t / MaxVal) for t below MaxVal * MaxVal + MaxVal
   function automatic logic [N-1:0] div_round(input logic [W-1:0] prod);
      logic [W-1:0] t;
      logic [W:0]   acc;
      t   = prod + W'(HalfVal);
      acc = (W+1)'(t) + (W+1)'(t >> N) + (W+1)'(1);
      return acc[W-1:N];
   endfunction

   // Select factors and multiply
   always_comb begin
      fac_src = pick_factor(cfg.src_factor, src_chan, dst_chan, src_alpha, dst_alpha,
                            const_chan, const_alpha, sat_factor);
      fac_dst = pick_factor(cfg.dst_factor, src_chan, dst_chan, src_alpha, dst_alpha,
                            const_chan, const_alpha, sat_factor);
      prod_src_in = W'(src_chan) * W'(fac_src);
      prod_dst_in = W'(dst_chan) * W'(fac_dst);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_prod) begin
         prod_src_ff <= prod_src_in;
         prod_dst_ff <= prod_dst_in;
         src_p_ff    <= src_chan;
         dst_p_ff    <= dst_chan;
      end
   end

   // Reduce products to unorm
   always_comb begin
      quot_src_in = div_round(prod_src_ff);
      quot_dst_in = div_round(prod_dst_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_quot) begin
         quot_src_ff <= quot_src_in;
         quot_dst_ff <= quot_dst_in;
         src_q_ff    <= src_p_ff;
         dst_q_ff    <= dst_p_ff;
      end
   end

   // Apply the blend equation
   always_comb begin
      sum = {1'b0, quot_src_ff} + {1'b0, quot_dst_ff};
      unique case (cfg.equation)
         cbu_pkg::EQ_ADD:     result = sum[N] ? MaxVal : sum[N-1:0];
         cbu_pkg::EQ_SUB:     result = (quot_src_ff > quot_dst_ff) ?
                                       quot_src_ff - quot_dst_ff : '0;
         cbu_pkg::EQ_REV_SUB: result = (quot_dst_ff > quot_src_ff) ?
                                       quot_dst_ff - quot_src_ff : '0;
         cbu_pkg::EQ_MIN:     result = (src_q_ff < dst_q_ff) ? src_q_ff : dst_q_ff;
         cbu_pkg::EQ_MAX:     result = (src_q_ff > dst_q_ff) ? src_q_ff : dst_q_ff;
         default:             result = '0;
      endcase
   end

endmodule

// ----- src/cbu_checker.sv -----
// Port-level checks for the color blend unit, attached by bind.
// Depends on color_blend_unit's port list only.
module cbu_checker #(
   parameter int CHANNEL_BITS = 8
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [CHANNEL_BITS-1:0] rsp_out_red,
   input logic [CHANNEL_BITS-1:0] rsp_out_green,
   input logic [CHANNEL_BITS-1:0] rsp_out_blue,
   input logic [CHANNEL_BITS-1:0] rsp_out_alpha
);

   // Drop any result word on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // An accepted word is followed by a result word (its own or an older one) on show
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> ##3 rsp_valid)
      else $error("no result three cycles after an accepted word");

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_red)
         && $stable(rsp_out_green) && $stable(rsp_out_blue) && $stable(rsp_out_alpha)))
      else $error("stalled result word changed");

endmodule

bind color_blend_unit cbu_checker #(
   .CHANNEL_BITS (CHANNEL_BITS)
) u_cbu_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_red   (rsp_out_red),
   .rsp_out_green (rsp_out_green),
   .rsp_out_blue  (rsp_out_blue),
   .rsp_out_alpha (rsp_out_alpha)
);
